// File: sv/vdir_pkg.sv
// ----------------------------------------------------------------------------
// vdir_pkg
// Shared types and constants for the vertex dedup and index remap block.
// ----------------------------------------------------------------------------
package vdir_pkg;

    localparam int WORD_W     = 64;
    localparam int WPV_W      = 4;
    localparam int INDEX_W    = 8;
    localparam int TOTAL_W    = 9;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam logic [WPV_W-1:0] WPV_RESET = 4'd3;

    typedef struct packed {
        logic capture;
        logic search_start;
        logic search_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic complete;
        logic done;
        logic out_free;
    } ctrl_stat_t;

endpackage

// File: sv/vdir_ram.sv
// ----------------------------------------------------------------------------
// vdir_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vdir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/vdir_ctrl.sv
// ----------------------------------------------------------------------------
// vdir_ctrl
// Sequencer: take words, scan the unique store, hand off the result beat.
// ----------------------------------------------------------------------------
module vdir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output vdir_pkg::ctrl_cmd_t cmd,
    input  vdir_pkg::ctrl_stat_t stat
);

    import vdir_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_PUSH   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd.capture      = 1'b0;
        cmd.search_start = 1'b0;
        cmd.search_step  = 1'b0;
        cmd.out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid && stat.complete)
                begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/vdir_datapath.sv
// ----------------------------------------------------------------------------
// vdir_datapath
// Word assembly, unique store scan and compare, result and output registers.
// ----------------------------------------------------------------------------
module vdir_datapath #(
    parameter int MAX_UNIQUE = 256,
    parameter int MAX_WORDS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vdir_pkg::WPV_W-1:0]           cfg_wdata,
    input  logic                                 mesh_start,
    input  logic [vdir_pkg::WORD_W-1:0]          s_word,
    input  vdir_pkg::ctrl_cmd_t                  cmd,
    output vdir_pkg::ctrl_stat_t                 stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [vdir_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [vdir_pkg::OUT_USER_W-1:0]      m_tuser
);

    import vdir_pkg::*;

    localparam int CW = $clog2(MAX_UNIQUE + 1);
    localparam int AW = $clog2(MAX_UNIQUE);
    localparam int LW = $clog2(MAX_WORDS + 1);
    localparam int PW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int EW = MAX_WORDS * WORD_W;

    logic [WPV_W-1:0]  wpv_reg;
    logic [WPV_W-1:0]  wpv_next;
    logic [LW-1:0]     len;

    logic [LW-1:0]     pos_reg;
    logic [LW-1:0]     pos_next;
    logic [LW-1:0]     pos_base;
    logic [LW-1:0]     pos_clamp;
    logic [LW-1:0]     pos_inc;

    logic [WORD_W-1:0] pend_reg [MAX_WORDS];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     scan_reg;
    logic [CW-1:0]     scan_next;
    logic              cmp_valid_reg;
    logic              cmp_valid_next;
    logic [CW-1:0]     cmp_idx_reg;
    logic [CW-1:0]     cmp_idx_next;

    logic [CW-1:0]     res_idx_reg;
    logic [CW-1:0]     res_idx_next;
    logic              res_new_reg;
    logic              res_new_next;
    logic              res_ovf_reg;
    logic              res_ovf_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg;
    logic [OUT_USER_W-1:0] m_user_next;

    logic [EW-1:0]     rd_data;
    logic [EW-1:0]     wr_data;
    logic              rd_en;
    logic              wr_en;
    logic              match;
    logic              hit;
    logic              scan_more;
    logic              done;
    logic              complete;
    logic              out_free;
    logic              commit;
    logic              room;
    logic [INDEX_W-1:0] idx_sat;
    logic [TOTAL_W-1:0] total_sat;

    // effective vertex length
    always_comb
    begin
        wpv_next = cfg_we ? cfg_wdata : wpv_reg;
        if (wpv_reg == '0)
        begin
            len = LW'(1);
        end
        else if (int'(wpv_reg) > MAX_WORDS)
        begin
            len = LW'(MAX_WORDS);
        end
        else
        begin
            len = LW'(wpv_reg);
        end
    end

    // word position
    always_comb
    begin
        pos_base  = mesh_start ? '0 : pos_reg;
        pos_clamp = (int'(pos_base) >= MAX_WORDS) ? LW'(MAX_WORDS - 1) : pos_base;
        pos_inc   = pos_clamp + LW'(1);
        complete  = (pos_inc >= len);
        pos_next  = pos_reg;
        if (cmd.capture)
        begin
            pos_next = complete ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pend_reg[pos_clamp[PW-1:0]] <= s_word;
        end
    end

    // compare the fetched entry against the pending vertex
    always_comb
    begin
        match   = 1'b1;
        wr_data = '0;
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            if (w < int'(len))
            begin
                wr_data[w*WORD_W +: WORD_W] = pend_reg[w];
                if (rd_data[w*WORD_W +: WORD_W] != pend_reg[w])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit       = cmp_valid_reg && match;
        scan_more = (scan_reg < count_reg);
        done      = hit || (!cmp_valid_reg && !scan_more);
        commit    = cmd.search_step && done;
        room      = (int'(count_reg) < MAX_UNIQUE);
        rd_en     = cmd.search_step && !hit && scan_more;
        wr_en     = commit && !hit && room;

        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        if (cmd.search_start)
        begin
            scan_next      = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.search_step)
        begin
            cmp_valid_next = rd_en;
            if (rd_en)
            begin
                cmp_idx_next = scan_reg;
                scan_next    = scan_reg + CW'(1);
            end
        end

        count_next = count_reg;
        if (cmd.capture && mesh_start)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end

        res_idx_next = res_idx_reg;
        res_new_next = res_new_reg;
        res_ovf_next = res_ovf_reg;
        if (commit)
        begin
            res_idx_next = hit ? cmp_idx_reg : count_reg;
            res_new_next = !hit && room;
            res_ovf_next = !hit && !room;
        end
    end

    // output beat
    always_comb
    begin
        idx_sat   = (int'(res_idx_reg) > 255) ? 8'd255 : INDEX_W'(res_idx_reg);
        total_sat = (int'(count_reg) > 511) ? 9'd511 : TOTAL_W'(count_reg);
        out_free     = !m_valid_reg || m_tready;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_DATA_W'({total_sat, idx_sat});
            m_user_next  = {res_ovf_reg, res_new_reg};
        end
    end

    assign stat = {complete, done, out_free};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpv_reg       <= WPV_RESET;
            pos_reg       <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            wpv_reg       <= wpv_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        res_idx_reg <= res_idx_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    vdir_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_UNIQUE)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: sv/vertex_dedup_index_remap_top.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap_top
// Exact-match vertex deduplication with compacted index remap.
// ----------------------------------------------------------------------------
// Flow: each word is captured while idle; a final word also starts a scan of the N
//   stored vertices (one store row per cycle through the registered RAM read port)
//   that ends at a match or at the end of the store, then the output beat is loaded.
// No new word is taken until the beat is loaded and the block is idle again;
//   a held output beat stalls the load and the input.
// Reset: clears control, counts and words_per_vertex (to 3); the store is not
//   cleared and needs no clearing pass.
module vertex_dedup_index_remap_top #(
    parameter int MAX_UNIQUE = 256,
    parameter int MAX_WORDS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vdir_pkg::WPV_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vdir_pkg::IN_DATA_W-1:0]  s_tdata,   // vertex_word[63:0]
    input  logic                            s_tuser,   // mesh_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vdir_pkg::OUT_DATA_W-1:0] m_tdata,   // vertex_index[7:0], unique_total[16:8]
    output logic [vdir_pkg::OUT_USER_W-1:0] m_tuser    // is_new[0], overflow[1]
);

    import vdir_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    vdir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vdir_datapath #(
        .MAX_UNIQUE (MAX_UNIQUE),
        .MAX_WORDS  (MAX_WORDS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mesh_start (s_tuser),
        .s_word     (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: sim/vertex_dedup_index_remap_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap_top_tb
// Self-checking bench for the vertex dedup and index remap block.
// Streams vertex words into the block under a range of vertex lengths and
// idle patterns. An in-bench dedup predictor keeps its own unique store and
// queues the expected remap beat for every completed vertex. Each output beat
// is checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module vertex_dedup_index_remap_top_tb;
    import vdir_pkg::*;

    localparam int MAX_UNIQUE   = 256;
    localparam int MAX_WORDS    = 8;
    localparam int QUIET_CYCLES = 300;
    localparam int ITEM_TARGET  = 1250;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               overflow;
        logic [TOTAL_W-1:0] unique_total;
    } remap_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [WPV_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // vertex_word[63:0]
    logic                  s_tuser;    // mesh_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // vertex_index[7:0], unique_total[16:8]
    logic [OUT_USER_W-1:0] m_tuser;    // is_new[0], overflow[1]

    remap_beat_t       remap_q[$];
    logic [WORD_W-1:0] uniq_store [MAX_UNIQUE][MAX_WORDS];
    logic [WORD_W-1:0] pend_words [MAX_WORDS];
    int unsigned       uniq_count;
    int unsigned       word_pos;
    logic [WPV_W-1:0]  wpv_reg;

    int mismatches     = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    vertex_dedup_index_remap_top #(
        .MAX_UNIQUE (MAX_UNIQUE),
        .MAX_WORDS  (MAX_WORDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hold off for a counted stretch, else stall at random
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        remap_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (remap_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: index %0d new %0b ovf %0b total %0d",
                             m_tdata[7:0], m_tuser[0], m_tuser[1], m_tdata[16:8]);
            end
            else
            begin
                want = remap_q.pop_front();
                if (m_tdata[7:0] !== want.vertex_index || m_tuser[0] !== want.is_new ||
                    m_tuser[1] !== want.overflow || m_tdata[16:8] !== want.unique_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch (exp/act): index %0d/%0d new %0b/%0b",
                                  " ovf %0b/%0b total %0d/%0d"},
                                 want.vertex_index, m_tdata[7:0], want.is_new, m_tuser[0],
                                 want.overflow, m_tuser[1], want.unique_total, m_tdata[16:8]);
                end
            end
        end
    end

    function automatic int eff_len(input logic [WPV_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WORDS)
            return MAX_WORDS;
        return int'(v);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic predict_remap(input logic mesh_start, input logic [WORD_W-1:0] word);
        remap_beat_t beat;
        int          len;
        int unsigned idx;
        logic        found;
        logic        same;
        len   = eff_len(wpv_reg);
        found = 1'b0;
        idx   = 0;
        if (mesh_start)
        begin
            uniq_count = 0;
            word_pos   = 0;
        end
        if (word_pos >= MAX_WORDS)
            word_pos = MAX_WORDS - 1;
        pend_words[word_pos] = word;
        word_pos++;
        if (word_pos < len)
            return;
        word_pos = 0;
        for (int e = 0; e < uniq_count && !found; e++)
        begin
            same = 1'b1;
            for (int w = 0; w < len; w++)
                if (uniq_store[e][w] != pend_words[w])
                    same = 1'b0;
            if (same)
            begin
                found = 1'b1;
                idx   = e;
            end
        end
        beat.is_new   = 1'b0;
        beat.overflow = 1'b0;
        if (!found)
        begin
            idx = uniq_count;
            if (uniq_count < MAX_UNIQUE)
            begin
                for (int w = 0; w < MAX_WORDS; w++)
                    uniq_store[uniq_count][w] = (w < len) ? pend_words[w] : '0;
                uniq_count++;
                beat.is_new = 1'b1;
            end
            else
            begin
                beat.overflow = 1'b1;
            end
        end
        beat.vertex_index = (idx > 255) ? 8'd255 : idx[INDEX_W-1:0];
        beat.unique_total = (uniq_count > 511) ? 9'd511 : uniq_count[TOTAL_W-1:0];
        remap_q = {remap_q, beat};
    endtask

    task automatic send_word(input logic mesh_start, input logic [WORD_W-1:0] word);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mesh_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        predict_remap(mesh_start, word);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (remap_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_wpv(input logic [WPV_W-1:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        wpv_reg = value;
    endtask

    task automatic set_phase(input int phase);
        case (phase)
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            3: begin send_idle_pct = 21; recv_stall_pct = 21; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    task automatic test_extremes();
        set_phase(0);
        write_wpv(4'd1);
        send_word(1'b1, '0);
        send_word(1'b0, '1);
        send_word(1'b0, '0);
        write_wpv(4'd15);
        for (int w = 0; w < MAX_WORDS; w++)
            send_word(w == 0, (w % 3 == 0) ? '1 : (w % 3 == 1) ? 64'hAAAA_5555_AAAA_5555 : '0);
        write_wpv(4'd0);
        send_word(1'b1, 64'h8000_0000_0000_0001);
        send_word(1'b0, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_zero_tail();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        write_wpv(4'd2);
        send_word(1'b1, a);
        send_word(1'b0, b);
        write_wpv(4'd3);
        send_word(1'b0, a);
        send_word(1'b0, b);
        send_word(1'b0, '0);
        send_word(1'b0, a);
        send_word(1'b0, b);
        send_word(1'b0, 64'h1);
    endtask

    task automatic test_mid_vertex_cfg();
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        c = {$urandom, $urandom};
        d = {$urandom, $urandom};
        write_wpv(4'd4);
        send_word(1'b1, c);
        send_word(1'b0, d);
        write_wpv(4'd2);
        send_word(1'b0, {$urandom, $urandom});
        send_word(1'b0, c);
        send_word(1'b0, d);
    endtask

    task automatic test_mid_vertex_start();
        logic [WORD_W-1:0] f;
        logic [WORD_W-1:0] g;
        f = {$urandom, $urandom};
        g = {$urandom, $urandom};
        write_wpv(4'd3);
        send_word(1'b1, f);
        send_word(1'b0, g);
        send_word(1'b1, g);
        send_word(1'b0, f);
        send_word(1'b0, g);
    endtask

    task automatic test_store_full();
        logic [WORD_W-1:0] kept [MAX_UNIQUE];
        write_wpv(4'd1);
        set_phase(3);
        for (int i = 0; i < MAX_UNIQUE; i++)
        begin
            kept[i] = {$urandom, $urandom};
            send_word(i == 0, kept[i]);
        end
        repeat (3) send_word(1'b0, {$urandom, $urandom});
        send_word(1'b0, kept[MAX_UNIQUE-1]);
        send_word(1'b0, kept[0]);
        send_word(1'b0, kept[$urandom_range(MAX_UNIQUE-1)]);
        send_word(1'b0, {$urandom, $urandom});
        set_phase(0);
    endtask

    task automatic test_backpressure();
        write_wpv(4'd2);
        set_phase(0);
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_word(i == 0, WORD_W'($urandom_range(3)));
    endtask

    task automatic test_random_meshes();
        logic [WORD_W-1:0] pool [16][MAX_WORDS];
        logic [WORD_W-1:0] vtx [MAX_WORDS];
        logic [WPV_W-1:0]  wpv;
        logic              first;
        int                mesh_num;
        int                len;
        int                n_pool;
        int                n_vtx;
        int                pick;
        int                src;
        int                cut;
        mesh_num = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (mesh_num % 3 == 0)
            begin
                wpv = ($urandom_range(3) == 0) ? WPV_W'($urandom_range(15))
                                               : WPV_W'($urandom_range(1, 4));
                write_wpv(wpv);
            end
            set_phase(mesh_num % 5);
            len    = eff_len(wpv_reg);
            n_pool = $urandom_range(1, 16);
            for (int p = 0; p < n_pool; p++)
                for (int w = 0; w < MAX_WORDS; w++)
                    pool[p][w] = rand_word();
            // drop a stray partial vertex ahead of the new mesh
            if (len > 1 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, len - 1)) send_word(1'b0, rand_word());
            n_vtx = $urandom_range(1, 40);
            first = 1'b1;
            for (int k = 0; k < n_vtx; k++)
            begin
                pick = $urandom_range(9);
                src  = $urandom_range(n_pool - 1);
                for (int w = 0; w < MAX_WORDS; w++)
                    vtx[w] = (pick < 9) ? pool[src][w] : rand_word();
                if (pick >= 7 && pick < 9)
                    vtx[$urandom_range(len - 1)][$urandom_range(WORD_W - 1)] ^= 1'b1;
                cut = (len > 1 && $urandom_range(49) == 0) ? $urandom_range(1, len - 1) : len;
                for (int w = 0; w < cut; w++)
                begin
                    send_word(first, vtx[w]);
                    first = 1'b0;
                end
                if (cut < len)
                    first = 1'b1;
            end
            mesh_num++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        wpv_reg    = WPV_RESET;
        uniq_count = 0;
        word_pos   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_tail();
        test_mid_vertex_cfg();
        test_mid_vertex_start();
        test_store_full();
        test_backpressure();
        test_random_meshes();

        wait_quiet();
        if (mismatches == 0 && remap_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/vdir_pkg.sv
sv/vdir_ram.sv
sv/vdir_ctrl.sv
sv/vdir_datapath.sv
sv/vertex_dedup_index_remap_top.sv
sim/vertex_dedup_index_remap_top_tb.sv
